### rtl/core/etx_pkg.sv
// etx_pkg: shared constants, types and helpers for the extended tekhex encoder
// used by every module in rtl/core but the two interfaces; depends on nothing
package etx_pkg;

  // record geometry
  localparam int MAX_RECORD_BYTES = 16;
  localparam int BUF_AW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
  localparam int CNT_W  = 5;
  localparam int POS_W  = 6;
  localparam int STEP_W = 3;

  // fixed characters
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_LF      = 8'h0a;

  // record type and address length digits
  localparam logic [3:0] REC_DATA       = 4'h6;
  localparam logic [3:0] REC_TERM       = 4'h8;
  localparam logic [3:0] ADDR_LEN_DIGIT = 4'h8;
  localparam logic [7:0] LEN_BASE       = 8'd14;

  // character positions within a record
  localparam logic [POS_W-1:0] POS_START     = 6'd0;
  localparam logic [POS_W-1:0] POS_LEN_HI    = 6'd1;
  localparam logic [POS_W-1:0] POS_LEN_LO    = 6'd2;
  localparam logic [POS_W-1:0] POS_TYPE      = 6'd3;
  localparam logic [POS_W-1:0] POS_SUM_HI    = 6'd4;
  localparam logic [POS_W-1:0] POS_SUM_LO    = 6'd5;
  localparam logic [POS_W-1:0] POS_ALEN      = 6'd6;
  localparam logic [POS_W-1:0] POS_ADDR_LAST = 6'd14;
  localparam logic [POS_W-1:0] POS_DATA      = 6'd15;

  // checksum steps through the shared adder
  localparam logic [STEP_W-1:0] STEP_LEN   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_BYTES = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ADDR0 = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LAST  = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_EMIT,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic       pair;
  } sum_op_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [3:0]       rec_type;
    logic [7:0]       len;
    logic [7:0]       csum;
    logic [31:0]      addr;
    logic [CNT_W-1:0] byte_count;
    logic [7:0]       rd_data;
  } rec_view_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eor;
    logic       data_lo;
  } char_info_t;

  // upper case ascii hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'h0, v};
    end else begin
      r = 8'h37 + {4'h0, v};
    end
    return r;
  endfunction

endpackage

### rtl/core/etx_in_if.sv
// etx_in_if: input channel of the tekhex encoder, one data or termination item
// depends on nothing
interface etx_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, kind, data_byte, last, input ready);
  modport sink   (input valid, kind, data_byte, last, output ready);
endinterface

### rtl/core/etx_out_if.sv
// etx_out_if: output channel of the tekhex encoder, one record character per item
// depends on nothing
interface etx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       end_of_record;

  modport source (output valid, out_char, end_of_record, input ready);
  modport sink   (input valid, out_char, end_of_record, output ready);
endinterface

### rtl/core/etx_byte_buf.sv
// etx_byte_buf: record byte buffer, one write and one registered read port
// depends on etx_pkg
module etx_byte_buf
  import etx_pkg::*;
(
  input  logic              clk,
  input  buf_wr_t           wr,
  input  logic [BUF_AW-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [MAX_RECORD_BYTES];

  // write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/core/etx_sum_unit.sv
// etx_sum_unit: shared 8-bit adder for the running and final nibble sums
// depends on etx_pkg
module etx_sum_unit
  import etx_pkg::*;
(
  input  sum_op_t    op,
  output logic [7:0] res
);

  logic [7:0] addend;

  // addend is either the byte itself or the sum of its two nibbles
  always_comb begin
    if (op.pair) begin
      addend = {4'h0, op.b[7:4]} + {4'h0, op.b[3:0]};
    end else begin
      addend = op.b;
    end
  end

  assign res = op.a + addend;

endmodule

### rtl/core/etx_char_gen.sv
// etx_char_gen: picks the record character for the current position
// depends on etx_pkg
module etx_char_gen
  import etx_pkg::*;
(
  input  rec_view_t  view,
  output char_info_t info
);

  logic [POS_W-1:0] data_end;
  logic [POS_W-1:0] addr_k;
  logic [POS_W-1:0] data_off;
  logic [3:0]       addr_nib;

  // end of the data digits, address nibble index, offset into data digits
  assign data_end = POS_DATA + {view.byte_count, 1'b0};
  assign addr_k   = POS_ADDR_LAST - view.pos;
  assign data_off = view.pos - POS_DATA;
  assign addr_nib = 4'(view.addr >> {addr_k[2:0], 2'b00});

  always_comb begin
    info = '0;
    if (view.pos == POS_START) begin
      info.ch = CH_PERCENT;
    end else if (view.pos == POS_LEN_HI) begin
      info.ch = hex_char(view.len[7:4]);
    end else if (view.pos == POS_LEN_LO) begin
      info.ch = hex_char(view.len[3:0]);
    end else if (view.pos == POS_TYPE) begin
      info.ch = hex_char(view.rec_type);
    end else if (view.pos == POS_SUM_HI) begin
      info.ch = hex_char(view.csum[7:4]);
    end else if (view.pos == POS_SUM_LO) begin
      info.ch = hex_char(view.csum[3:0]);
    end else if (view.pos == POS_ALEN) begin
      info.ch = hex_char(ADDR_LEN_DIGIT);
    end else if (view.pos < POS_DATA) begin
      info.ch = hex_char(addr_nib);
    end else if (view.pos < data_end) begin
      // high digit then low digit of each buffered byte
      if (data_off[0]) begin
        info.ch      = hex_char(view.rd_data[3:0]);
        info.data_lo = 1'b1;
      end else begin
        info.ch = hex_char(view.rd_data[7:4]);
      end
    end else if (view.pos == data_end) begin
      info.ch = CH_CR;
    end else begin
      info.ch  = CH_LF;
      info.eor = 1'b1;
    end
  end

endmodule

### rtl/core/extended_tekhex_record_encoder_core.sv
// extended_tekhex_record_encoder_core: buffers bytes and writes tekhex records
// depends on etx_pkg, etx_in_if, etx_out_if, etx_byte_buf, etx_sum_unit, etx_char_gen
//
//  channel  | dir | payload                    | handshake
//  ---------+-----+----------------------------+-------------------------------
//  in_ch    | in  | kind, data_byte, last      | valid/ready, 1 item per record byte
//  out_ch   | out | out_char, end_of_record    | valid/ready, 1 item per character
//  cfg      | in  | cfg_wdata (start address)  | cfg_we, written the same edge
//
// A byte that does not close a record is taken without a stall.
// A closing byte or termination item then takes six checksum steps on the
// shared adder, 17 + 2n characters and a buffer fetch after each data byte (n bytes),
// and waits while out_ch holds ready low; in_ch is not ready meanwhile.
// The next item is taken while the closing line feed still waits in the output
// register. Synchronous active-high reset, no clearing pass.
module extended_tekhex_record_encoder_core
  import etx_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  etx_in_if.sink      in_ch,
  etx_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  state_t            state;
  state_t            state_next;
  logic [POS_W-1:0]  pos;
  logic [STEP_W-1:0] step;
  logic [7:0]        csum;
  logic [3:0]        rec_type;
  logic [BUF_AW-1:0] rd_idx;
  logic [CNT_W-1:0]  byte_count;
  logic [7:0]        nibble_sum;
  logic [31:0]       cur_addr;
  logic              out_valid;
  logic [7:0]        out_char;
  logic              out_eor;

  logic              accept;
  logic              load;
  logic              room;
  logic              closing;
  logic [CNT_W-1:0]  count_after;
  logic [7:0]        len;
  logic [1:0]        addr_k;
  logic [7:0]        sum_res;
  logic [7:0]        rd_data;
  sum_op_t           sum_op;
  buf_wr_t           buf_wr;
  rec_view_t         view;
  char_info_t        info;

  // submodules
  etx_byte_buf u_buf (
    .clk     (clk),
    .wr      (buf_wr),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  etx_sum_unit u_sum (
    .op  (sum_op),
    .res (sum_res)
  );

  etx_char_gen u_chr (
    .view (view),
    .info (info)
  );

  // item bookkeeping
  assign accept      = in_ch.valid && in_ch.ready;
  assign room        = byte_count < CNT_W'(MAX_RECORD_BYTES);
  assign count_after = room ? byte_count + 5'd1 : byte_count;
  assign closing     = in_ch.kind || in_ch.last || (count_after >= CNT_W'(MAX_RECORD_BYTES));
  assign len         = LEN_BASE + {2'b00, byte_count, 1'b0};
  assign addr_k      = 2'(step - STEP_ADDR0);

  // view of the record for the character picker
  always_comb begin
    view.pos        = pos;
    view.rec_type   = rec_type;
    view.len        = len;
    view.csum       = csum;
    view.addr       = cur_addr;
    view.byte_count = byte_count;
    view.rd_data    = rd_data;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && closing) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (step == STEP_LAST) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load) begin
          if (info.eor) begin
            state_next = ST_IDLE;
          end else if (info.data_lo) begin
            state_next = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_next = ST_EMIT;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control outputs and shared adder operands
  always_comb begin
    in_ch.ready = 1'b0;
    load        = 1'b0;
    sum_op      = '0;
    buf_wr.en   = 1'b0;
    buf_wr.addr = byte_count[BUF_AW-1:0];
    buf_wr.data = in_ch.data_byte;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        sum_op.a    = nibble_sum;
        sum_op.b    = in_ch.data_byte;
        sum_op.pair = 1'b1;
        buf_wr.en   = accept && !in_ch.kind && room;
      end
      ST_SUM: begin
        sum_op.a = csum;
        if (step == STEP_LEN) begin
          sum_op.b    = len;
          sum_op.pair = 1'b1;
        end else if (step == STEP_BYTES) begin
          sum_op.b    = nibble_sum;
          sum_op.pair = 1'b0;
        end else begin
          sum_op.b    = 8'(cur_addr >> {addr_k, 3'b000});
          sum_op.pair = 1'b1;
        end
      end
      ST_EMIT: begin
        load = !out_valid || out_ch.ready;
      end
      ST_FETCH: begin
        load = 1'b0;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      byte_count <= '0;
      nibble_sum <= '0;
      cur_addr   <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        cur_addr <= cfg_wdata;
      end
      if (accept) begin
        if (in_ch.kind) begin
          byte_count <= '0;
          nibble_sum <= '0;
        end else if (room) begin
          byte_count <= count_after;
          nibble_sum <= sum_res;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
        if (info.eor) begin
          cur_addr   <= cur_addr + 32'(byte_count);
          byte_count <= '0;
          nibble_sum <= '0;
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // record sequencing registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rec_type <= in_ch.kind ? REC_TERM : REC_DATA;
      csum     <= {4'h0, ADDR_LEN_DIGIT} + {4'h0, (in_ch.kind ? REC_TERM : REC_DATA)};
      step     <= STEP_LEN;
      pos      <= POS_START;
      rd_idx   <= '0;
    end
    if (state == ST_SUM) begin
      csum <= sum_res;
      step <= step + 3'd1;
    end
    if (load) begin
      out_char <= info.ch;
      out_eor  <= info.eor;
      pos      <= pos + 6'd1;
      if (info.data_lo) begin
        rd_idx <= rd_idx + 1'b1;
      end
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.out_char      = out_char;
  assign out_ch.end_of_record = out_eor;

`ifndef SYNTHESIS
  a_eor_is_lf : assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.end_of_record |-> out_ch.out_char == CH_LF)
    else $error("end of record flagged on a character other than line feed");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_W'(MAX_RECORD_BYTES))
    else $error("byte count beyond buffer size");

  a_close_clears : assert property (@(posedge clk) disable iff (rst)
    load && info.eor |=> state == ST_IDLE && byte_count == '0)
    else $error("record close did not return to idle with an empty buffer");

  a_pos_bound : assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> pos <= POS_DATA + 6'd1 + {byte_count, 1'b0})
    else $error("character position ran past the line feed");

  a_fetch_after_emit : assert property (@(posedge clk) disable iff (rst)
    state == ST_FETCH |-> $past(state) == ST_EMIT)
    else $error("buffer fetch without a preceding data digit");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// testbench for extended_tekhex_record_encoder_core: random and directed record traffic
// with a scoreboard predicting every record character; depends on etx_pkg, etx_in_if,
// etx_out_if and the encoder core

package etx_tb_pkg;
  import etx_pkg::*;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_TERM = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eor;
  } tekhex_char_t;

  class tekhex_scoreboard;
    tekhex_char_t expected_chars[$];
    logic [31:0]  next_addr;
    logic [7:0]   pend_bytes[MAX_RECORD_BYTES];
    int unsigned  pend_count;
    logic [7:0]   pend_sum;
    int unsigned  mismatches;
    int unsigned  records;

    function new();
      next_addr  = '0;
      pend_count = 0;
      pend_sum   = '0;
      mismatches = 0;
      records    = 0;
    endfunction

    // a start address write also moves the load address of the next record
    function void set_start_address(logic [31:0] value);
      next_addr = value;
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    function logic [7:0] hex_digit(logic [3:0] v);
      string digits;
      digits = "0123456789ABCDEF";
      return digits[v];
    endfunction

    function int unsigned nib_sum(logic [7:0] b);
      return b[7:4] + b[3:0];
    endfunction

    function void push_char(logic [7:0] ch, logic eor);
      tekhex_char_t c;
      c.ch  = ch;
      c.eor = eor;
      expected_chars.push_back(c);
    endfunction

    function void push_hex_byte(logic [7:0] b);
      push_char(hex_digit(b[7:4]), 1'b0);
      push_char(hex_digit(b[3:0]), 1'b0);
    endfunction

    // build the whole record text from the pending bytes and the load address
    function void close_record(logic [3:0] rec_type);
      logic [7:0]  len;
      int unsigned total;
      logic [7:0]  csum;
      len   = LEN_BASE + 8'(2 * pend_count);
      total = ADDR_LEN_DIGIT + rec_type + nib_sum(len) + pend_sum;
      for (int i = 0; i < 4; i++) begin
        total += nib_sum(next_addr[8*i +: 8]);
      end
      csum = total[7:0];
      push_char(CH_PERCENT, 1'b0);
      push_hex_byte(len);
      push_char(hex_digit(rec_type), 1'b0);
      push_hex_byte(csum);
      push_char(hex_digit(ADDR_LEN_DIGIT), 1'b0);
      for (int i = 3; i >= 0; i--) begin
        push_hex_byte(next_addr[8*i +: 8]);
      end
      for (int i = 0; i < pend_count; i++) begin
        push_hex_byte(pend_bytes[i]);
      end
      push_char(CH_CR, 1'b0);
      push_char(CH_LF, 1'b1);
      next_addr  = next_addr + pend_count;
      pend_count = 0;
      pend_sum   = '0;
    endfunction

    // accepted input item: buffer the byte, close the record where due
    function void note_input(item_kind_e kind_in, logic [7:0] byte_in, logic closes);
      if (kind_in == KIND_TERM) begin
        // pending bytes are dropped, the termination record has no data
        pend_count = 0;
        pend_sum   = '0;
        close_record(REC_TERM);
      end else begin
        if (pend_count < MAX_RECORD_BYTES) begin
          pend_bytes[pend_count] = byte_in;
          pend_count++;
          pend_sum = pend_sum + 8'(nib_sum(byte_in));
        end
        // a full buffer closes the record whatever last says
        if (closes || pend_count >= MAX_RECORD_BYTES) begin
          close_record(REC_DATA);
        end
      end
    endfunction

    function void report(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: %s", $time, what);
      end
    endfunction

    // accepted output item: compare with the oldest expected character
    function void check_result(logic [7:0] ch, logic eor);
      tekhex_char_t exp_c;
      if (eor === 1'b1) begin
        records++;
      end
      if (expected_chars.size() == 0) begin
        report($sformatf("unexpected char %h eor %b", ch, eor));
        return;
      end
      exp_c = expected_chars.pop_front();
      if (ch !== exp_c.ch) begin
        report($sformatf("out_char expected %h got %h", exp_c.ch, ch));
      end
      if (eor !== exp_c.eor) begin
        report($sformatf("end_of_record expected %b got %b", exp_c.eor, eor));
      end
    endfunction
  endclass

endpackage

module testbench;
  import etx_pkg::*;
  import etx_tb_pkg::*;

  localparam int LIMIT       = 300000;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 400;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  etx_in_if  in_ch();
  etx_out_if out_ch();

  extended_tekhex_record_encoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tekhex_scoreboard sb = new();

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int unsigned hold_gen = 0;
  int unsigned items_sent = 0;
  int unsigned addr_writes = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // output side: check accepted chars, drive ready with random stalls and long holds
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.out_char, out_ch.end_of_record);
      end
      if (hold_gen != hold_seen) begin
        hold_seen = hold_gen;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // offer one item, with random idle cycles first
  task automatic send_item(item_kind_e kind_in, logic [7:0] byte_in, logic closes);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind_in;
    in_ch.data_byte <= byte_in;
    in_ch.last      <= closes;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(kind_in, byte_in, closes);
    items_sent++;
  endtask

  // stop offering until every expected char has come, then let the block settle
  task automatic drain(int settle);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_start_address(logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_start_address(value);
    addr_writes++;
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed records, some termination items and runs that miss their last flag
  task automatic send_random_record();
    int unsigned r;
    int unsigned n;
    logic        closes;
    r = $urandom_range(99);
    if (r < 10) begin
      send_item(KIND_TERM, 8'($urandom), 1'($urandom));
    end else begin
      if (r < 80) begin
        n = $urandom_range(1, 5);
      end else if (r < 93) begin
        n = $urandom_range(6, 16);
      end else begin
        n = $urandom_range(17, 24);
      end
      for (int i = 0; i < n; i++) begin
        closes = (i == n - 1) && ($urandom_range(9) != 0);
        send_item(KIND_DATA, 8'($urandom), closes);
      end
    end
  endtask

  task automatic run_random(int unsigned count);
    int unsigned first;
    first = items_sent;
    while (items_sent - first < count) send_random_record();
  endtask

  // stimulus
  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_DATA;
    in_ch.data_byte <= '0;
    in_ch.last      <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // first phase: sender idles a quarter of the time, receiver nearly half
    tx_idle_pct = 25;
    rx_idle_pct = 45;
    write_start_address(32'h0000_0000);

    // termination with nothing pending, single byte extremes
    send_item(KIND_TERM, 8'hff, 1'b1);
    send_item(KIND_DATA, 8'h00, 1'b1);
    send_item(KIND_DATA, 8'hff, 1'b1);
    // termination drops pending bytes
    send_item(KIND_DATA, 8'ha5, 1'b0);
    send_item(KIND_DATA, 8'h5a, 1'b0);
    send_item(KIND_TERM, 8'h00, 1'b0);
    drain(SETTLE);

    // full buffer closes on its own, and the address wraps past the top
    write_start_address(32'hffff_fff8);
    for (int i = 0; i < MAX_RECORD_BYTES; i++) begin
      send_item(KIND_DATA, 8'($urandom), 1'b0);
    end
    send_item(KIND_TERM, 8'h3c, 1'b1);

    // long output hold while the sender keeps offering items
    hold_gen <= hold_gen + 1;
    run_random(25);
    drain(SETTLE);

    // second phase: idle rates swapped, random start address
    tx_idle_pct = 45;
    rx_idle_pct = 25;
    write_start_address($urandom);
    run_random(13);
    drain(0);
    run_random(12);
    drain(SETTLE);

    // third phase: no idling on either side, top address
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_start_address(32'hffff_ffff);
    run_random(25);
    drain(SETTLE);

    $display("covered %0d input items, %0d records, %0d start address writes,",
             items_sent, sb.records, addr_writes);
    $display("three idle patterns and a long output hold, %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
